/* design/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, step functions and saturation for the cylinder pair pipeline.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int SqrtSteps = 33;  // one root bit per stage, 66-bit radicand
  localparam int DivSteps  = 34;  // one quotient bit per stage

  // word carried alongside the square root
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic [31:0]        s;
    logic signed [34:0] h;
    logic               hit;
  } cpc_side_t;

  // word carried alongside the dividers
  typedef struct packed {
    logic [31:0]        s;
    logic signed [34:0] h;
    logic               hit;
    logic               neg_x;
    logic               neg_z;
    logic               zero;
  } cpc_tail_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [32:0] root;
  } cpc_sq_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [33:0] low;  // numerator bits shift out, quotient bits shift in
  } cpc_dv_t;

  function automatic cpc_sq_t cpc_sqrt_step(cpc_sq_t cur, logic [1:0] pair);
    cpc_sq_t     nxt;
    logic [35:0] rsh;
    logic [35:0] trial;
    rsh   = {cur.rem[33:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (rsh >= trial) begin
      nxt.rem  = rsh - trial;
      nxt.root = {cur.root[31:0], 1'b1};
    end else begin
      nxt.rem  = rsh;
      nxt.root = {cur.root[31:0], 1'b0};
    end
    return nxt;
  endfunction

  function automatic cpc_dv_t cpc_div_step(cpc_dv_t cur, logic [32:0] d);
    cpc_dv_t     nxt;
    logic [34:0] rsh;
    logic        ge;
    rsh     = {cur.rem[33:0], cur.low[33]};
    ge      = (rsh >= {2'b00, d});
    nxt.rem = ge ? (rsh - {2'b00, d}) : rsh;
    nxt.low = {cur.low[32:0], ge};
    return nxt;
  endfunction

  function automatic logic [31:0] cpc_sat(logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/cpc_front.sv */
// ----------------------------------------------------------------------------
// cpc_front
// Differences, squares and overlap tests: three register stages.
// ----------------------------------------------------------------------------
module cpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  a_z,
  input  logic [30:0]         a_radius,
  input  logic [30:0]         a_height,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  b_z,
  input  logic [30:0]         b_radius,
  input  logic [30:0]         b_height,
  output logic                out_valid,
  output logic [65:0]         n,
  output cpc_pkg::cpc_side_t  side
);
  import cpc_pkg::*;

  logic               v1, v2;
  logic signed [32:0] dx1, dz1;
  logic [31:0]        s1;
  logic signed [34:0] up1, down1;

  logic [63:0]        dx2, dz2, s2;
  cpc_side_t          side2;

  logic signed [32:0] dxa, dza;
  logic signed [34:0] up_c, down_c;
  logic [64:0]        dist2;

  always_comb begin
    up_c   = {{3{b_y[31]}}, b_y} + {4'b0000, b_height} - {{3{a_y[31]}}, a_y};
    down_c = {{3{a_y[31]}}, a_y} + {4'b0000, a_height} - {{3{b_y[31]}}, b_y};
    dxa    = dx1[32] ? -dx1 : dx1;
    dza    = dz1[32] ? -dz1 : dz1;
    dist2  = {1'b0, dx2} + {1'b0, dz2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= {b_x[31], b_x} - {a_x[31], a_x};
      dz1   <= {b_z[31], b_z} - {a_z[31], a_z};
      s1    <= {1'b0, a_radius} + {1'b0, b_radius};
      up1   <= up_c;
      down1 <= down_c;

      dx2         <= dxa[31:0] * dxa[31:0];
      dz2         <= dza[31:0] * dza[31:0];
      s2          <= s1 * s1;
      side2.dx    <= dx1;
      side2.dz    <= dz1;
      side2.s     <= s1;
      side2.h     <= (up1 < down1) ? up1 : down1;
      side2.hit   <= (up1 > 35'sd0) && (down1 > 35'sd0);

      n        <= {1'b0, dist2};
      side.dx  <= side2.dx;
      side.dz  <= side2.dz;
      side.s   <= side2.s;
      side.h   <= side2.h;
      side.hit <= side2.hit && (dist2 < {1'b0, s2});
    end
  end

endmodule

/* design/cpc_sqrt.sv */
// ----------------------------------------------------------------------------
// cpc_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cpc_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [65:0]        n,
  input  cpc_pkg::cpc_side_t side_in,
  output logic               out_valid,
  output logic [32:0]        root,
  output cpc_pkg::cpc_side_t side_out
);
  import cpc_pkg::*;

  logic      v    [1:SqrtSteps];
  cpc_sq_t   sq   [1:SqrtSteps];
  logic [65:0] nsh [1:SqrtSteps-1];
  cpc_side_t side [1:SqrtSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= SqrtSteps; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[1] <= in_valid;
      for (int k = 2; k <= SqrtSteps; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[1]   <= cpc_sqrt_step('0, n[65:64]);
      nsh[1]  <= {n[63:0], 2'b00};
      side[1] <= side_in;
      for (int k = 2; k <= SqrtSteps; k++) begin
        sq[k]   <= cpc_sqrt_step(sq[k-1], nsh[k-1][65:64]);
        side[k] <= side[k-1];
      end
      for (int k = 2; k < SqrtSteps; k++) nsh[k] <= {nsh[k-1][63:0], 2'b00};
    end
  end

  assign out_valid = v[SqrtSteps];
  assign root      = sq[SqrtSteps].root;
  assign side_out  = side[SqrtSteps];

endmodule

/* design/cpc_div.sv */
// ----------------------------------------------------------------------------
// cpc_div
// Radial scale: |dv|*|s-d| then two pipelined restoring dividers by d.
// ----------------------------------------------------------------------------
module cpc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [32:0]        d,
  input  cpc_pkg::cpc_side_t side_in,
  output logic               out_valid,
  output logic [33:0]        qx,
  output logic [33:0]        qz,
  output cpc_pkg::cpc_tail_t tail_out
);
  import cpc_pkg::*;

  logic signed [34:0] m;
  logic signed [34:0] ma;
  logic signed [32:0] dxa, dza;

  logic        vp1, vp2;
  logic [31:0] mx1, mz1;
  logic [33:0] mm1;
  logic [32:0] d1, d2;
  cpc_tail_t   tail1, tail2;
  logic [65:0] px2, pz2;

  logic        v    [1:DivSteps];
  cpc_dv_t     dvx  [1:DivSteps];
  cpc_dv_t     dvz  [1:DivSteps];
  logic [32:0] dd   [1:DivSteps-1];
  cpc_tail_t   tail [1:DivSteps];

  always_comb begin
    m   = $signed({3'b000, side_in.s}) - $signed({2'b00, d});
    ma  = m[34] ? -m : m;
    dxa = side_in.dx[32] ? -side_in.dx : side_in.dx;
    dza = side_in.dz[32] ? -side_in.dz : side_in.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
      vp2 <= 1'b0;
      for (int k = 1; k <= DivSteps; k++) v[k] <= 1'b0;
    end else if (en) begin
      vp1  <= in_valid;
      vp2  <= vp1;
      v[1] <= vp2;
      for (int k = 2; k <= DivSteps; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1         <= dxa[31:0];
      mz1         <= dza[31:0];
      mm1         <= ma[33:0];
      d1          <= d;
      tail1.s     <= side_in.s;
      tail1.h     <= side_in.h;
      tail1.hit   <= side_in.hit;
      tail1.neg_x <= side_in.dx[32] ^ m[34];
      tail1.neg_z <= side_in.dz[32] ^ m[34];
      tail1.zero  <= (d == 33'd0);

      px2   <= mx1 * mm1;
      pz2   <= mz1 * mm1;
      d2    <= d1;
      tail2 <= tail1;

      // quotient fits in 34 bits, so the top bits start as the remainder
      dvx[1]  <= cpc_div_step({3'b000, px2[65:34], px2[33:0]}, d2);
      dvz[1]  <= cpc_div_step({3'b000, pz2[65:34], pz2[33:0]}, d2);
      dd[1]   <= d2;
      tail[1] <= tail2;
      for (int k = 2; k <= DivSteps; k++) begin
        dvx[k]  <= cpc_div_step(dvx[k-1], dd[k-1]);
        dvz[k]  <= cpc_div_step(dvz[k-1], dd[k-1]);
        tail[k] <= tail[k-1];
      end
      for (int k = 2; k < DivSteps; k++) dd[k] <= dd[k-1];
    end
  end

  assign out_valid = v[DivSteps];
  assign qx        = dvx[DivSteps].low;
  assign qz        = dvz[DivSteps].low;
  assign tail_out  = tail[DivSteps];

endmodule

/* design/cpc_back.sv */
// ----------------------------------------------------------------------------
// cpc_back
// Signs the radial push, compares push lengths and saturates the result word.
// ----------------------------------------------------------------------------
module cpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [33:0]        qx,
  input  logic [33:0]        qz,
  input  cpc_pkg::cpc_tail_t tail,
  output logic               out_valid,
  output logic               hit,
  output logic signed [31:0] push_x,
  output logic signed [31:0] push_y,
  output logic signed [31:0] push_z
);
  import cpc_pkg::*;

  logic               v1, v2;
  logic signed [34:0] rx1, rz1, h1, rx2, rz2, h2;
  logic               hit1, hit2;
  logic [67:0]        rxs, rzs, hs;

  logic signed [34:0] rx_c, rz_c, rxa, rza, ha;
  logic [68:0]        rlen;
  logic               pick;

  always_comb begin
    if (tail.zero) begin
      rx_c = $signed({3'b000, tail.s});
      rz_c = '0;
    end else begin
      rx_c = tail.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      rz_c = tail.neg_z ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
    end
    rxa  = rx1[34] ? -rx1 : rx1;
    rza  = rz1[34] ? -rz1 : rz1;
    ha   = h1[34] ? -h1 : h1;
    rlen = {1'b0, rxs} + {1'b0, rzs};
    pick = rlen < {1'b0, hs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx1  <= rx_c;
      rz1  <= rz_c;
      h1   <= tail.h;
      hit1 <= tail.hit;

      rxs  <= rxa[33:0] * rxa[33:0];
      rzs  <= rza[33:0] * rza[33:0];
      hs   <= ha[33:0] * ha[33:0];
      rx2  <= rx1;
      rz2  <= rz1;
      h2   <= h1;
      hit2 <= hit1;

      hit    <= hit2;
      push_x <= pick ? cpc_sat(rx2) : 32'sd0;
      push_y <= pick ? 32'sd0 : cpc_sat(h2);
      push_z <= pick ? cpc_sat(rz2) : 32'sd0;
    end
  end

endmodule

/* design/cylinder_pair_collision.sv */
// ----------------------------------------------------------------------------
// cylinder_pair_collision
// Upright cylinder pair overlap test with push vector, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: pair_valid / pair_stall with the two cylinders' fields.
// Output channel: result_valid / result_stall with hit and push_x/y/z.
// A word is taken when valid is high and stall is low.
// The stages run in order: differences and squares, the square root (one
// root bit per stage), the products and the two dividers (one quotient bit
// per stage), then signing, length compare and output. Throughput is one
// pair per cycle while no result is stalled; every stage is a register, so
// the longest path is a 34-bit multiply or a 36-bit compare and subtract.
// The whole pipeline advances together; while a result is held by
// result_stall, every stage holds and pair_stall is raised.
// Synchronous reset clears all valid bits; the block takes words on the
// first cycle after reset.
// ----------------------------------------------------------------------------
module cylinder_pair_collision (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic [30:0]        a_radius,
  input  logic [30:0]        a_height,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic [30:0]        b_radius,
  input  logic [30:0]        b_height,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               hit,
  output logic signed [31:0] push_x,
  output logic signed [31:0] push_y,
  output logic signed [31:0] push_z
);
  import cpc_pkg::*;

  logic        en;
  logic        f_valid, s_valid, d_valid;
  logic [65:0] n;
  cpc_side_t   f_side, s_side;
  logic [32:0] root;
  logic [33:0] qx, qz;
  cpc_tail_t   tail;

  // hold everything while the output word waits
  assign en         = !(result_valid && result_stall);
  assign pair_stall = !en;

  cpc_front u_front (
    .clk, .rst, .en,
    .in_valid (pair_valid),
    .a_x, .a_y, .a_z, .a_radius, .a_height,
    .b_x, .b_y, .b_z, .b_radius, .b_height,
    .out_valid(f_valid),
    .n,
    .side     (f_side)
  );

  cpc_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (f_valid),
    .n,
    .side_in  (f_side),
    .out_valid(s_valid),
    .root,
    .side_out (s_side)
  );

  cpc_div u_div (
    .clk, .rst, .en,
    .in_valid (s_valid),
    .d        (root),
    .side_in  (s_side),
    .out_valid(d_valid),
    .qx, .qz,
    .tail_out (tail)
  );

  cpc_back u_back (
    .clk, .rst, .en,
    .in_valid (d_valid),
    .qx, .qz,
    .tail,
    .out_valid(result_valid),
    .hit, .push_x, .push_y, .push_z
  );

  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pair_stall |-> result_valid)
    else $error("input stalled with no waiting result");

  a_push_axis: assert property (@(posedge clk) disable iff (rst)
    result_valid && push_y != 32'sd0 |-> push_x == 32'sd0 && push_z == 32'sd0)
    else $error("height push mixed with radial push");

  a_hit_up: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit |-> push_y >= 32'sd0)
    else $error("downward height push on a hit");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams cylinder pairs through cylinder_pair_collision under four idle and
// stall mixes. Each accepted pair is scored by a local overlap and push
// calculation. Each result word is checked field by field against the oldest
// expected word.
// ----------------------------------------------------------------------------
module testbench;
  import cpc_pkg::*;

  localparam int NumRandom = 1650;
  localparam int WatchLimit = 4000;

  typedef struct {
    logic signed [31:0] a_x, a_y, a_z;
    logic [30:0]        a_radius, a_height;
    logic signed [31:0] b_x, b_y, b_z;
    logic [30:0]        b_radius, b_height;
  } pair_t;

  typedef struct {
    logic        hit;
    logic [31:0] push_x, push_y, push_z;
  } push_t;

  logic clk = 0;
  logic rst = 1;
  logic pair_valid = 0;
  logic pair_stall;
  logic signed [31:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
  logic [30:0] a_radius = 0, a_height = 0, b_radius = 0, b_height = 0;
  logic result_valid;
  logic result_stall = 0;
  logic hit;
  logic signed [31:0] push_x, push_y, push_z;

  pair_t pending_pairs[$];
  push_t expected_pushes[$];
  int total_pairs = 0;
  int accepted_pairs = 0;
  int errors = 0;
  int quiet_cycles = 0;

  cylinder_pair_collision dut (.*);

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic push_t collide(pair_t p);
    logic signed [127:0] ax, ay, az, ar, ah, bx, by, bz, br, bh;
    logic signed [127:0] dx, dz, s, dist2, up, down, h, d, c, rx, rz;
    push_t r;
    ax = p.a_x; ay = p.a_y; az = p.a_z; ar = p.a_radius; ah = p.a_height;
    bx = p.b_x; by = p.b_y; bz = p.b_z; br = p.b_radius; bh = p.b_height;
    dx = bx - ax;
    dz = bz - az;
    s = ar + br;
    dist2 = dx * dx + dz * dz;
    up = by + bh - ay;
    down = ay + ah - by;
    h = (up < down) ? up : down;
    d = 0;
    for (int b = 34; b >= 0; b--) begin
      c = d | (128'sd1 <<< b);
      if (c * c <= dist2) d = c;
    end
    if (d == 0) begin
      rx = s;
      rz = 0;
    end else begin
      rx = (dx * (s - d)) / d;
      rz = (dz * (s - d)) / d;
    end
    r.hit = (dist2 < s * s) && (up > 0) && (down > 0);
    if (rx * rx + rz * rz < h * h) begin
      r.push_x = clamp32(rx);
      r.push_y = 0;
      r.push_z = clamp32(rz);
    end else begin
      r.push_x = 0;
      r.push_y = clamp32(h);
      r.push_z = 0;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic pair_t make_pair(logic signed [31:0] ax, ay, az, logic [30:0] ar, ah,
                                      logic signed [31:0] bx, by, bz, logic [30:0] br, bh);
    pair_t p;
    p.a_x = ax; p.a_y = ay; p.a_z = az; p.a_radius = ar; p.a_height = ah;
    p.b_x = bx; p.b_y = by; p.b_z = bz; p.b_radius = br; p.b_height = bh;
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int k;
    logic [31:0] mask;
    p.a_x = $urandom; p.a_y = $urandom; p.a_z = $urandom;
    p.a_radius = 31'($urandom); p.a_height = 31'($urandom);
    p.b_x = $urandom; p.b_y = $urandom; p.b_z = $urandom;
    p.b_radius = 31'($urandom); p.b_height = 31'($urandom);
    if ($urandom_range(99) < 70) begin
      // nearby pair at a random scale, so overlaps and both push kinds show up
      k = $urandom_range(2, 30);
      mask = (32'd1 << k) - 32'd1;
      p.a_radius &= mask[30:0]; p.b_radius &= mask[30:0];
      p.a_height &= mask[30:0]; p.b_height &= mask[30:0];
      p.b_x = p.a_x + $signed(($urandom & mask) - (mask >> 1));
      p.b_y = p.a_y + $signed(($urandom & mask) - (mask >> 1));
      p.b_z = p.a_z + $signed(($urandom & mask) - (mask >> 1));
      if ($urandom_range(9) == 0) begin
        p.b_x = p.a_x;
        p.b_z = p.a_z;
      end
    end
    return p;
  endfunction

  initial begin
    // directed: extremes, coincident axes, touching, apart, deep overlap
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 65536, 65536, 0, 0, 0, 65536, 65536));
    pending_pairs.push_back(make_pair(0, 0, 0, '1, '1, 0, 0, 0, '1, '1));
    pending_pairs.push_back(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1, '1,
                                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, '1));
    pending_pairs.push_back(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0,
                                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 3, 10, 5, 0, 0, 2, 10));
    pending_pairs.push_back(make_pair(0, 0, 0, 3, 10, 3, 4, 4, 2, 10));
    pending_pairs.push_back(make_pair(0, 0, 0, 100, 1000, 10, 5, -7, 100, 1000));
    pending_pairs.push_back(make_pair(0, 0, 0, 100, 3, 10, 1, -7, 100, 1000));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 1000, 1000, 1000, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 10, 0, 10, 0, 1, 10));
    pending_pairs.push_back(make_pair(-5, -5, -5, 1 << 20, 1 << 20, 5, 5, 5, 1 << 20, 3));
    pending_pairs.push_back(make_pair(0, 0, 0, '1, 1, 1, 0, 1, '1, 1));
    pending_pairs.push_back(make_pair(32'sh8000_0000, 0, 0, '1, '1,
                                      32'sh7FFF_FFFF, 0, 0, '1, '1));
    for (int i = 0; i < NumRandom; i++) pending_pairs.push_back(random_pair());
    total_pairs = pending_pairs.size();
    repeat (6) @(posedge clk);
    rst <= 0;
    wait (pending_pairs.size() == 0 && accepted_pairs == total_pairs
          && expected_pushes.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_pushes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  function automatic int idle_share();
    case (accepted_pairs * 4 / (total_pairs + 1))
      1: return 58;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_share();
    case (accepted_pairs * 4 / (total_pairs + 1))
      2: return 58;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  // driver: advance to the next word once the current one is taken
  always @(posedge clk) begin
    pair_t p;
    if (rst) begin
      pair_valid <= 0;
    end else begin
      if (pair_valid && !pair_stall) begin
        expected_pushes.push_back(collide(make_pair(a_x, a_y, a_z, a_radius, a_height,
                                                    b_x, b_y, b_z, b_radius, b_height)));
        accepted_pairs++;
      end
      if (!pair_valid || !pair_stall) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_share()) begin
          p = pending_pairs.pop_front();
          a_x <= p.a_x; a_y <= p.a_y; a_z <= p.a_z;
          a_radius <= p.a_radius; a_height <= p.a_height;
          b_x <= p.b_x; b_y <= p.b_y; b_z <= p.b_z;
          b_radius <= p.b_radius; b_height <= p.b_height;
          pair_valid <= 1;
        end else begin
          pair_valid <= 0;
        end
      end
    end
  end

  // monitor: score each taken result word against the oldest expectation
  always @(posedge clk) begin
    push_t w;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_pushes.size() == 0) begin
          report("unexpected word", push_x, 0);
        end else begin
          w = expected_pushes.pop_front();
          if (hit !== w.hit) report("hit", hit, w.hit);
          if (push_x !== w.push_x) report("push_x", push_x, w.push_x);
          if (push_y !== w.push_y) report("push_y", push_y, w.push_y);
          if (push_z !== w.push_z) report("push_z", push_z, w.push_z);
        end
      end
      result_stall <= ($urandom_range(99) < stall_share());
    end
  end

  // watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pair_valid && !pair_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
